// ===== hdl/crfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crfp_pkg
// Shared types, character codes and name tables for the cron field parser.
// ----------------------------------------------------------------------------
package crfp_pkg;

  localparam int unsigned PIECE_W     = 7;
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic REG_MAX_VALUE = 1'b0;
  localparam logic REG_MIN_VALUE = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [PIECE_W-1:0] DIGIT_SAT = 7'd127;

  // names packed with the first letter in the low byte
  localparam logic [23:0] DAY_NAMES [7] = '{
    24'h6E7573, 24'h6E6F6D, 24'h657574, 24'h646577,
    24'h756874, 24'h697266, 24'h746173
  };
  localparam logic [23:0] MONTH_NAMES [12] = '{
    24'h6E616A, 24'h626566, 24'h72616D, 24'h727061,
    24'h79616D, 24'h6E756A, 24'h6C756A, 24'h677561,
    24'h706573, 24'h74636F, 24'h766F6E, 24'h636564
  };

  // one command from the front to the back
  typedef struct packed {
    logic               has_elem;
    logic               last;
    logic [PIECE_W-1:0] first;
    logic [PIECE_W-1:0] stop;
    logic [PIECE_W-1:0] step;
  } cmd_t;

  function automatic logic [PIECE_W-1:0] piece_value(
    input logic [2:0]         len,
    input logic [23:0]        letters,
    input logic [PIECE_W-1:0] digits
  );
    logic [PIECE_W-1:0] v;
    logic               hit;
    v   = digits;
    hit = 1'b0;
    if (len == 3'd3) begin
      for (int k = 0; k < 7; k++) begin
        if (!hit && letters == DAY_NAMES[k]) begin
          v   = PIECE_W'(k);
          hit = 1'b1;
        end
      end
      for (int k = 0; k < 12; k++) begin
        if (!hit && letters == MONTH_NAMES[k]) begin
          v   = PIECE_W'(k + 1);
          hit = 1'b1;
        end
      end
    end
    return v;
  endfunction

  function automatic logic is_star(input logic [2:0] len, input logic [23:0] letters);
    return (len == 3'd1) && (letters == {16'h0000, CH_STAR});
  endfunction

endpackage

// ===== hdl/crfp_stream_if.sv =====
// ----------------------------------------------------------------------------
// crfp_stream_if
// Valid/ready channels for field characters and parsed results.
// ----------------------------------------------------------------------------
interface crfp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface crfp_result_if #(
  parameter int unsigned MAP_BITS = 64
);
  localparam int unsigned CNT_W = $clog2(MAP_BITS + 1);

  logic                valid;
  logic                ready;
  logic [MAP_BITS-1:0] enabled_map;
  logic [CNT_W-1:0]    enabled_count;

  modport source (output valid, output enabled_map, output enabled_count, input ready);
  modport sink   (input valid, input enabled_map, input enabled_count, output ready);
endinterface

// ===== hdl/crfp_front.sv =====
// ----------------------------------------------------------------------------
// crfp_front
// Character front end: tracks pieces and elements, emits fill commands.
// ----------------------------------------------------------------------------
module crfp_front
  import crfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  crfp_char_if.sink          char_i,
  input  logic [5:0]         max_value_i,
  input  logic               min_value_i,
  input  logic               q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    PH_BEGIN = 2'd0,
    PH_END   = 2'd1,
    PH_STEP  = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [PIECE_W-1:0] begin_q, begin_d, end_q, end_d, step_q, step_d;
  logic [PIECE_W-1:0] digits_q, digits_d;
  logic [23:0]        letters_q, letters_d;
  logic [2:0]         len_q, len_d;
  logic               open_q, open_d;
  logic               star_q, star_d;
  logic               used_q, used_d;
  logic               dash_q, dash_d;
  logic               halted_q, halted_d;

  logic               accept;
  logic [7:0]         c;
  logic [7:0]         c_low;
  logic [10:0]        dig_sum;
  logic [PIECE_W-1:0] v_cur, v_fin;
  logic               finish;
  logic [PIECE_W-1:0] e_beg, e_end, e_step;
  logic               e_star;

  assign char_i.ready = !q_full_i;
  assign accept       = char_i.valid && !q_full_i;
  assign c            = char_i.char_code;
  assign c_low        = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
  assign dig_sum      = 11'(digits_q) * 11'd10 + 11'(c - CH_ZERO);
  assign v_cur        = piece_value(len_q, letters_q, digits_q);

  // state after the character itself, before any element close
  always_comb begin
    phase_d   = phase_q;
    begin_d   = begin_q;
    end_d     = end_q;
    step_d    = step_q;
    digits_d  = digits_q;
    letters_d = letters_q;
    len_d     = len_q;
    open_d    = open_q;
    star_d    = star_q;
    used_d    = used_q;
    dash_d    = dash_q;
    halted_d  = halted_q;
    if (!halted_q) begin
      if (c == CH_COMMA) begin
        if (!used_q) begin
          halted_d = 1'b1;
        end
      end else begin
        used_d = 1'b1;
        if (c == CH_DASH && phase_q == PH_BEGIN) begin
          begin_d   = v_cur;
          star_d    = is_star(len_q, letters_q);
          phase_d   = PH_END;
          dash_d    = 1'b1;
          digits_d  = '0;
          letters_d = '0;
          len_d     = '0;
          open_d    = 1'b1;
        end else if (c == CH_SLASH && phase_q != PH_STEP) begin
          if (phase_q == PH_BEGIN) begin
            begin_d = v_cur;
            star_d  = is_star(len_q, letters_q);
          end else begin
            end_d = v_cur;
          end
          phase_d   = PH_STEP;
          digits_d  = '0;
          letters_d = '0;
          len_d     = '0;
          open_d    = 1'b1;
        end else begin
          if (open_q && c >= CH_ZERO && c <= CH_NINE) begin
            digits_d = (dig_sum > 11'(DIGIT_SAT)) ? DIGIT_SAT : dig_sum[PIECE_W-1:0];
          end else begin
            open_d = 1'b0;
          end
          case (len_q)
            3'd0:    letters_d = letters_q | {16'h0000, c_low};
            3'd1:    letters_d = letters_q | {8'h00, c_low, 8'h00};
            3'd2:    letters_d = letters_q | {c_low, 16'h0000};
            default: letters_d = letters_q;
          endcase
          if (len_q < 3'd4) begin
            len_d = len_q + 3'd1;
          end
        end
      end
    end
  end

  assign finish = !halted_q &&
                  ((c == CH_COMMA && used_q) || (c != CH_COMMA && char_i.last));
  assign v_fin  = piece_value(len_d, letters_d, digits_d);

  // close the open piece into its slot and work out the range
  always_comb begin
    e_beg  = (phase_d == PH_BEGIN) ? v_fin : begin_d;
    e_star = (phase_d == PH_BEGIN) ? is_star(len_d, letters_d) : star_d;
    e_end  = (phase_d == PH_END) ? v_fin : end_d;
    e_step = (phase_d == PH_STEP) ? v_fin : PIECE_W'(1);
    cmd_o.has_elem = finish;
    cmd_o.last     = char_i.last;
    cmd_o.step     = e_step;
    if (dash_d) begin
      cmd_o.first = e_beg;
      cmd_o.stop  = e_end;
    end else if (e_star) begin
      cmd_o.first = PIECE_W'(min_value_i);
      cmd_o.stop  = PIECE_W'(max_value_i);
    end else begin
      cmd_o.first = e_beg;
      cmd_o.stop  = e_beg;
    end
  end

  assign push_o = accept && (finish || char_i.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BEGIN;
      begin_q   <= '0;
      end_q     <= '0;
      step_q    <= '0;
      digits_q  <= '0;
      letters_q <= '0;
      len_q     <= '0;
      open_q    <= 1'b1;
      star_q    <= 1'b0;
      used_q    <= 1'b0;
      dash_q    <= 1'b0;
      halted_q  <= 1'b0;
    end else if (accept) begin
      if (finish || char_i.last) begin
        phase_q   <= PH_BEGIN;
        begin_q   <= '0;
        end_q     <= '0;
        step_q    <= '0;
        digits_q  <= '0;
        letters_q <= '0;
        len_q     <= '0;
        open_q    <= 1'b1;
        star_q    <= 1'b0;
        used_q    <= 1'b0;
        dash_q    <= 1'b0;
        halted_q  <= char_i.last ? 1'b0 : halted_d;
      end else begin
        phase_q   <= phase_d;
        begin_q   <= begin_d;
        end_q     <= end_d;
        step_q    <= step_d;
        digits_q  <= digits_d;
        letters_q <= letters_d;
        len_q     <= len_d;
        open_q    <= open_d;
        star_q    <= star_d;
        used_q    <= used_d;
        dash_q    <= dash_d;
        halted_q  <= halted_d;
      end
    end
  end

endmodule

// ===== hdl/crfp_queue.sv =====
// ----------------------------------------------------------------------------
// crfp_queue
// Small command queue between the character front end and the fill engine.
// ----------------------------------------------------------------------------
module crfp_queue
  import crfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/crfp_back.sv =====
// ----------------------------------------------------------------------------
// crfp_back
// Fill engine: sets map bits one per cycle, counts them and emits the result.
// ----------------------------------------------------------------------------
module crfp_back
  import crfp_pkg::*;
#(
  parameter int unsigned MAP_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [5:0] max_value_i,
  input  logic       min_value_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  crfp_result_if.source res_o
);

  localparam int unsigned IDX_W = $clog2(MAP_BITS);
  localparam int unsigned CNT_W = $clog2(MAP_BITS + 1);
  localparam logic [PIECE_W-1:0] LIM_CAP = PIECE_W'(MAP_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_COUNT,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [MAP_BITS-1:0]  map_q;
  logic [PIECE_W:0]     pos_q;
  logic [PIECE_W-1:0]   end_q, step_q;
  logic                 last_q;
  logic [IDX_W-1:0]     scan_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_vld_q;
  logic [MAP_BITS-1:0]  out_map_q;
  logic [CNT_W-1:0]     out_cnt_q;

  logic [PIECE_W-1:0]   lim;
  logic [PIECE_W-1:0]   stop_cl;
  logic [PIECE_W-1:0]   scan_ext;
  logic                 scan_hit;
  logic                 out_free;

  assign lim      = ({1'b0, max_value_i} > LIM_CAP) ? LIM_CAP : {1'b0, max_value_i};
  assign stop_cl  = (cmd_i.stop > lim) ? lim : cmd_i.stop;
  assign scan_ext = {{(PIECE_W - IDX_W){1'b0}}, scan_q};
  assign scan_hit = map_q[scan_q] && (scan_q != '0 || !min_value_i) && (scan_ext <= lim);
  assign out_free = !out_vld_q || res_o.ready;
  assign pop_o    = (state_q == S_IDLE) && cmd_valid_i;

  assign res_o.valid         = out_vld_q;
  assign res_o.enabled_map   = out_map_q;
  assign res_o.enabled_count = out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      map_q     <= '0;
      pos_q     <= '0;
      end_q     <= '0;
      step_q    <= '0;
      last_q    <= 1'b0;
      scan_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      out_map_q <= '0;
      out_cnt_q <= '0;
    end else begin
      if (state_q == S_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            pos_q  <= {1'b0, cmd_i.first};
            end_q  <= stop_cl;
            step_q <= cmd_i.step;
            last_q <= cmd_i.last;
            scan_q <= '0;
            cnt_q  <= '0;
            if (cmd_i.has_elem) begin
              state_q <= S_FILL;
            end else begin
              state_q <= S_COUNT;
            end
          end
        end
        S_FILL: begin
          if (pos_q <= {1'b0, end_q} && step_q != '0) begin
            map_q[pos_q[IDX_W-1:0]] <= 1'b1;
            pos_q <= pos_q + {1'b0, step_q};
          end else begin
            // zero step sets only the start position
            if (pos_q <= {1'b0, end_q}) begin
              map_q[pos_q[IDX_W-1:0]] <= 1'b1;
            end
            state_q <= last_q ? S_COUNT : S_IDLE;
          end
        end
        S_COUNT: begin
          if (scan_hit) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          scan_q <= scan_q + IDX_W'(1);
          if (scan_q == IDX_W'(MAP_BITS - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_map_q <= map_q;
            out_cnt_q <= cnt_q;
            map_q     <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/cron_field_parser.sv =====
// ----------------------------------------------------------------------------
// cron_field_parser
// Parses the characters of one cron time field into a map of enabled values.
// ----------------------------------------------------------------------------
// The front end takes one character per cycle while the four-entry command
// queue has room. For each finished element the fill engine takes its
// command, sets each position of the element in turn and then closes it (a
// zero step sets only the start position), and the character marked last
// adds a count scan over all MAP_BITS map bits and a load of the result
// register. The result register lets the next field enter while a result
// still waits to be taken.
// There is no reset sweep: the map is cleared when its result is loaded.
module cron_field_parser
  import crfp_pkg::*;
#(
  parameter int unsigned MAP_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [5:0]    cfg_data_i,
  crfp_char_if.sink     char_i,
  crfp_result_if.source res_o
);

  logic [5:0] max_value_q;
  logic       min_value_q;
  logic       push, q_full, pop, q_valid;
  cmd_t       push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= 6'd59;
      min_value_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_VALUE: max_value_q <= cfg_data_i;
        REG_MIN_VALUE: min_value_q <= cfg_data_i[0];
        default:       max_value_q <= max_value_q;
      endcase
    end
  end

  crfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .max_value_i (max_value_q),
    .min_value_i (min_value_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  crfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  crfp_back #(
    .MAP_BITS (MAP_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_value_i (max_value_q),
    .min_value_i (min_value_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
